/* rtl/cla_pkg.sv */
// Shared types and constants for the command line argument splitter.
// No dependencies; used by every module under rtl/.
package cla_pkg;

  // Widths fixed by the word format
  localparam int CHAR_W = 8;
  localparam int REP_W  = 16;
  localparam int KIND_W = 2;

  // Defaults for top level parameters
  localparam int RUN_COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_CHARS    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARG_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_END = 2'd2;

  // Byte codes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  // Parser modes
  typedef enum logic [4:0] {
    MODE_START       = 5'b00001,
    MODE_PATH_QUOTED = 5'b00010,
    MODE_PATH_PLAIN  = 5'b00100,
    MODE_GAP         = 5'b01000,
    MODE_ARG         = 5'b10000
  } mode_t;

  // One result word
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [REP_W-1:0]  rep;
    logic [KIND_W-1:0] kind;
    logic              done;
  } res_t;

  // One queue entry: the one or two results caused by an input word
  typedef struct packed {
    logic has2;
    res_t r0;
    res_t r1;
  } entry_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic   vld;
    entry_t data;
  } q_head_t;

endpackage

/* rtl/cla_front.sv */
// Front end: accepts input words, runs the argv parser state and
// produces a queue entry per word that causes results. Uses cla_pkg.
module cla_front #(
  parameter int RUN_COUNT_BITS = cla_pkg::RUN_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [cla_pkg::CHAR_W-1:0] in_char,
  input  logic                      in_is_end,
  output logic                      push,
  output cla_pkg::entry_t           push_data
);

  // Backslash counter never needs more than the repeat field holds
  localparam int RUN_W = (RUN_COUNT_BITS < cla_pkg::REP_W) ? RUN_COUNT_BITS : cla_pkg::REP_W;

  cla_pkg::mode_t   mode_r, mode_nxt;
  logic [1:0]       ql_r, ql_nxt;
  logic             iqr_r, iqr_nxt;
  logic [RUN_W-1:0] bs_r, bs_nxt;

  logic             end_w, sp_w, is_q, is_bs, do_arg;
  logic [1:0]       cnt;
  cla_pkg::res_t    em [2];
  logic [1:0]       a_ql;
  logic [2:0]       q_inc;
  logic             a_iqr;
  logic [RUN_W-1:0] a_bs;
  logic [RUN_W-1:0] half;

  assign end_w = in_is_end || (in_char == cla_pkg::CH_NUL);
  assign sp_w  = (in_char == cla_pkg::CH_SPACE) ||
                 ((in_char >= cla_pkg::CH_TAB) && (in_char <= cla_pkg::CH_CR));
  assign is_q  = (in_char == cla_pkg::CH_QUOTE);
  assign is_bs = (in_char == cla_pkg::CH_BSLASH);

  // Parse one byte: next state and up to two results
  always_comb begin
    mode_nxt = mode_r;
    ql_nxt   = ql_r;
    iqr_nxt  = iqr_r;
    bs_nxt   = bs_r;
    cnt      = 2'd0;
    em[0]    = '0;
    em[1]    = '0;
    do_arg   = 1'b0;
    a_ql     = ql_r;
    a_iqr    = iqr_r;
    a_bs     = bs_r;
    half     = '0;
    q_inc    = '0;

    case (mode_r)
      cla_pkg::MODE_START: begin
        if (end_w) begin
          em[cnt[0]] = '{ch: '0, rep: '0, kind: cla_pkg::KIND_ARG_END, done: 1'b1};
          cnt = cnt + 2'd1;
          ql_nxt = '0; iqr_nxt = 1'b0; bs_nxt = '0;
        end else if (is_q) begin
          mode_nxt = cla_pkg::MODE_PATH_QUOTED;
        end else if (sp_w) begin
          em[cnt[0]] = '{ch: '0, rep: '0, kind: cla_pkg::KIND_ARG_END, done: 1'b0};
          cnt = cnt + 2'd1;
          mode_nxt = cla_pkg::MODE_GAP;
        end else begin
          em[cnt[0]] = '{ch: in_char, rep: 16'd1, kind: cla_pkg::KIND_CHARS, done: 1'b0};
          cnt = cnt + 2'd1;
          mode_nxt = cla_pkg::MODE_PATH_PLAIN;
        end
      end
      cla_pkg::MODE_PATH_QUOTED, cla_pkg::MODE_PATH_PLAIN: begin
        if (end_w) begin
          em[cnt[0]] = '{ch: '0, rep: '0, kind: cla_pkg::KIND_ARG_END, done: 1'b1};
          cnt = cnt + 2'd1;
          mode_nxt = cla_pkg::MODE_START;
          ql_nxt = '0; iqr_nxt = 1'b0; bs_nxt = '0;
        end else if ((mode_r == cla_pkg::MODE_PATH_QUOTED) ? is_q : sp_w) begin
          em[cnt[0]] = '{ch: '0, rep: '0, kind: cla_pkg::KIND_ARG_END, done: 1'b0};
          cnt = cnt + 2'd1;
          mode_nxt = cla_pkg::MODE_GAP;
        end else begin
          em[cnt[0]] = '{ch: in_char, rep: 16'd1, kind: cla_pkg::KIND_CHARS, done: 1'b0};
          cnt = cnt + 2'd1;
        end
      end
      cla_pkg::MODE_GAP: begin
        if (end_w) begin
          em[cnt[0]] = '{ch: '0, rep: '0, kind: cla_pkg::KIND_LINE_END, done: 1'b1};
          cnt = cnt + 2'd1;
          mode_nxt = cla_pkg::MODE_START;
          ql_nxt = '0; iqr_nxt = 1'b0; bs_nxt = '0;
        end else if (!sp_w) begin
          // open a fresh argument
          do_arg   = 1'b1;
          mode_nxt = cla_pkg::MODE_ARG;
          a_ql     = '0;
          a_iqr    = 1'b0;
          a_bs     = '0;
        end
      end
      cla_pkg::MODE_ARG: begin
        do_arg = 1'b1;
      end
      default: begin
        mode_nxt = cla_pkg::MODE_START;
        ql_nxt = '0; iqr_nxt = 1'b0; bs_nxt = '0;
      end
    endcase

    // Argument byte with backslash and quote rules
    if (do_arg) begin
      if (a_iqr && (end_w || !is_q)) begin
        a_iqr = 1'b0;
        if (a_ql == 2'd2) a_ql = 2'd0;
      end
      if (end_w) begin
        if (a_bs != '0) begin
          em[cnt[0]] = '{ch: cla_pkg::CH_BSLASH, rep: 16'(a_bs),
                         kind: cla_pkg::KIND_CHARS, done: 1'b0};
          cnt = cnt + 2'd1;
        end
        em[cnt[0]] = '{ch: '0, rep: '0, kind: cla_pkg::KIND_ARG_END, done: 1'b1};
        cnt = cnt + 2'd1;
        mode_nxt = cla_pkg::MODE_START;
        a_ql = '0; a_iqr = 1'b0; a_bs = '0;
      end else if (sp_w && (a_ql == 2'd0)) begin
        if (a_bs != '0) begin
          em[cnt[0]] = '{ch: cla_pkg::CH_BSLASH, rep: 16'(a_bs),
                         kind: cla_pkg::KIND_CHARS, done: 1'b0};
          cnt = cnt + 2'd1;
        end
        em[cnt[0]] = '{ch: '0, rep: '0, kind: cla_pkg::KIND_ARG_END, done: 1'b0};
        cnt = cnt + 2'd1;
        mode_nxt = cla_pkg::MODE_GAP;
        a_ql = '0; a_iqr = 1'b0; a_bs = '0;
      end else if (is_bs) begin
        // saturate at the counter's all-ones value
        if (a_bs != '1) a_bs = a_bs + RUN_W'(1);
      end else if (is_q) begin
        if (a_iqr) begin
          q_inc = {1'b0, a_ql} + 3'd1;
          if (q_inc >= 3'd3) begin
            em[cnt[0]] = '{ch: cla_pkg::CH_QUOTE, rep: 16'd1,
                           kind: cla_pkg::KIND_CHARS, done: 1'b0};
            cnt = cnt + 2'd1;
            a_ql = 2'd0;
          end else begin
            a_ql = q_inc[1:0];
          end
        end else begin
          half = a_bs >> 1;
          if (half != '0) begin
            em[cnt[0]] = '{ch: cla_pkg::CH_BSLASH, rep: 16'(half),
                           kind: cla_pkg::KIND_CHARS, done: 1'b0};
            cnt = cnt + 2'd1;
          end
          if (!a_bs[0]) begin
            a_ql = a_ql + 2'd1;
          end else begin
            em[cnt[0]] = '{ch: cla_pkg::CH_QUOTE, rep: 16'd1,
                           kind: cla_pkg::KIND_CHARS, done: 1'b0};
            cnt = cnt + 2'd1;
          end
          a_bs  = '0;
          a_iqr = 1'b1;
        end
      end else begin
        if (a_bs != '0) begin
          em[cnt[0]] = '{ch: cla_pkg::CH_BSLASH, rep: 16'(a_bs),
                         kind: cla_pkg::KIND_CHARS, done: 1'b0};
          cnt = cnt + 2'd1;
        end
        a_bs = '0;
        em[cnt[0]] = '{ch: in_char, rep: 16'd1, kind: cla_pkg::KIND_CHARS, done: 1'b0};
        cnt = cnt + 2'd1;
      end
      ql_nxt  = a_ql;
      iqr_nxt = a_iqr;
      bs_nxt  = a_bs;
    end
  end

  // Hand finished results to the queue
  assign push           = accept && (cnt != 2'd0);
  assign push_data.has2 = cnt[1];
  assign push_data.r0   = em[0];
  assign push_data.r1   = em[1];

  // Advance parser state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cla_pkg::MODE_START;
      ql_r   <= '0;
      iqr_r  <= 1'b0;
      bs_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      ql_r   <= ql_nxt;
      iqr_r  <= iqr_nxt;
      bs_r   <= bs_nxt;
    end
  end

endmodule

/* rtl/cla_queue.sv */
// Short register queue of result entries between front and back end.
// Uses cla_pkg entry types; DEPTH must be a power of two, at least 2.
module cla_queue #(
  parameter int DEPTH = cla_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cla_pkg::entry_t  push_data,
  input  logic             pop,
  output logic             full,
  output cla_pkg::q_head_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cla_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign head.vld  = (cnt_r != '0);
  assign head.data = mem_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/cla_back.sv */
// Back end: unpacks queue entries into single result words through
// an output register. Uses cla_pkg entry types.
module cla_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cla_pkg::q_head_t           head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cla_pkg::CHAR_W-1:0] out_char,
  output logic [cla_pkg::REP_W-1:0]  out_repeat_res,
  output logic [cla_pkg::KIND_W-1:0] out_kind,
  output logic                       out_line_done,
  output logic                       out_run_last
);

  logic          vld_r, vld_nxt;
  logic          sel_r, sel_nxt;
  logic          load, take, last;
  cla_pkg::res_t cur;
  cla_pkg::res_t res_r;
  logic          last_r;

  // Pick the next result of the head entry
  assign load = !vld_r || !out_stall;
  assign take = load && head.vld;
  assign cur  = sel_r ? head.data.r1 : head.data.r0;
  assign last = sel_r || !head.data.has2;
  assign pop  = take && last;

  always_comb begin
    vld_nxt = vld_r;
    sel_nxt = sel_r;
    if (load) vld_nxt = head.vld;
    if (take) sel_nxt = !last;
  end

  // Hold control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      res_r  <= cur;
      last_r <= last;
    end
  end

  assign out_valid      = vld_r;
  assign out_char       = res_r.ch;
  assign out_repeat_res = res_r.rep;
  assign out_kind       = res_r.kind;
  assign out_line_done  = res_r.done;
  assign out_run_last   = last_r;

endmodule

/* rtl/command_line_arg_splitter.sv */
// Top level of the command line argument splitter (argv tokenizer).
// Depends on cla_pkg, cla_front, cla_queue and cla_back.
//
//   Channel  Direction  Handshake             Word
//   in_      input      in_valid / in_stall   in_char, in_is_end
//   out_     output     out_valid / out_stall out_char, out_repeat_res, out_kind,
//                                             out_line_done, out_run_last
//
// One input word is taken per cycle while the result queue has room; the
// output register sends one result word per cycle while out_stall is low,
// so a word causing two results is sent as two result words in turn. An
// accepted word is written into the queue, then into the output register.
// Reset (rst_n low, synchronous) returns the parser to start of line and
// empties the queue. Output stalls back up through the QUEUE_DEPTH-entry
// queue before in_stall rises; words that cause no result still need room.
module command_line_arg_splitter #(
  parameter int RUN_COUNT_BITS = cla_pkg::RUN_COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH    = cla_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cla_pkg::CHAR_W-1:0] in_char,
  input  logic                       in_is_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cla_pkg::CHAR_W-1:0] out_char,
  output logic [cla_pkg::REP_W-1:0]  out_repeat_res,
  output logic [cla_pkg::KIND_W-1:0] out_kind,
  output logic                       out_line_done,
  output logic                       out_run_last
);

  logic             accept, push, pop, full;
  cla_pkg::entry_t  push_data;
  cla_pkg::q_head_t head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Parse and classify
  cla_front #(.RUN_COUNT_BITS(RUN_COUNT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_char   (in_char),
    .in_is_end (in_is_end),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple the two sides
  cla_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .head      (head)
  );

  // Deliver result words
  cla_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_repeat_res (out_repeat_res),
    .out_kind       (out_kind),
    .out_line_done  (out_line_done),
    .out_run_last   (out_run_last)
  );

endmodule

/* tb/arg_split_checker.sv */
// Checker for the argv splitter: tracks accepted input words, predicts result words.
// Compares each accepted result word in order and reports the count of mismatches.
// Depends on cla_pkg for widths, kinds, byte codes and parser modes.
module arg_split_checker
  import cla_pkg::*;
#(
  parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_is_end,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CHAR_W-1:0] out_char,
  input  logic [REP_W-1:0]  out_repeat_res,
  input  logic [KIND_W-1:0] out_kind,
  input  logic              out_line_done,
  input  logic              out_run_last,
  output int                fail_count,
  output int                expected_cnt,
  output int                words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [REP_W-1:0]  rep;
    logic [KIND_W-1:0] kind;
    logic              done;
    logic              last;
  } arg_word_t;

  // Backslash run saturates at the counter width, never above the repeat field
  localparam int RUN_MAX = (RUN_COUNT_BITS >= 16) ? 65535 : (1 << RUN_COUNT_BITS) - 1;

  // Predicted parser state
  mode_t            mode;
  logic [1:0]       quote_lvl;
  logic             quote_run;
  logic [REP_W-1:0] bs_run;

  arg_word_t expected_words[$];
  arg_word_t step_words[$];
  int        errors = 0;
  int        checked = 0;

  initial begin
    fail_count    = 0;
    expected_cnt  = 0;
    words_checked = 0;
  end

  function automatic bit is_blank(logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Hold at most two results per input word
  function automatic void emit_word(logic [CHAR_W-1:0] c, logic [REP_W-1:0] n,
                                    logic [KIND_W-1:0] k, logic d);
    arg_word_t w;
    if (step_words.size() >= 2) return;
    w = '{c, n, k, d, 1'b0};
    step_words.push_back(w);
  endfunction

  function automatic void clear_arg();
    quote_lvl = '0;
    quote_run = 1'b0;
    bs_run    = '0;
  endfunction

  function automatic void flush_run();
    if (bs_run != 0) emit_word(CH_BSLASH, bs_run, KIND_CHARS, 1'b0);
    bs_run = '0;
  endfunction

  function automatic void close_line(logic [KIND_W-1:0] k);
    emit_word(CH_NUL, '0, k, 1'b1);
    mode = MODE_START;
    clear_arg();
  endfunction

  // Argument body with backslash and quote rules
  function automatic void arg_char(logic [CHAR_W-1:0] c, logic e);
    logic [REP_W-1:0] half;
    if (quote_run && (e || c != CH_QUOTE)) begin
      quote_run = 1'b0;
      if (quote_lvl == 2'd2) quote_lvl = 2'd0;
    end
    if (e) begin
      flush_run();
      close_line(KIND_ARG_END);
    end else if (is_blank(c) && quote_lvl == 2'd0) begin
      flush_run();
      emit_word(CH_NUL, '0, KIND_ARG_END, 1'b0);
      mode = MODE_GAP;
      clear_arg();
    end else if (c == CH_BSLASH) begin
      if (bs_run < RUN_MAX) bs_run = bs_run + 1'b1;
    end else if (c == CH_QUOTE) begin
      if (quote_run) begin
        quote_lvl = quote_lvl + 2'd1;
        if (quote_lvl == 2'd3) begin
          emit_word(CH_QUOTE, 16'd1, KIND_CHARS, 1'b0);
          quote_lvl = 2'd0;
        end
      end else begin
        half = bs_run >> 1;
        if (half != 0) emit_word(CH_BSLASH, half, KIND_CHARS, 1'b0);
        if (!bs_run[0]) quote_lvl = quote_lvl + 2'd1;
        else emit_word(CH_QUOTE, 16'd1, KIND_CHARS, 1'b0);
        bs_run    = '0;
        quote_run = 1'b1;
      end
    end else begin
      flush_run();
      emit_word(c, 16'd1, KIND_CHARS, 1'b0);
    end
  endfunction

  // Advance the parser by one input word and queue its results
  function automatic void split_byte(logic [CHAR_W-1:0] c, logic is_end);
    logic e;
    e = is_end || c == CH_NUL;
    step_words.delete();
    case (mode)
      MODE_START: begin
        if (e) close_line(KIND_ARG_END);
        else if (c == CH_QUOTE) mode = MODE_PATH_QUOTED;
        else if (is_blank(c)) begin
          emit_word(CH_NUL, '0, KIND_ARG_END, 1'b0);
          mode = MODE_GAP;
        end else begin
          emit_word(c, 16'd1, KIND_CHARS, 1'b0);
          mode = MODE_PATH_PLAIN;
        end
      end
      MODE_PATH_QUOTED: begin
        if (e) close_line(KIND_ARG_END);
        else if (c == CH_QUOTE) begin
          emit_word(CH_NUL, '0, KIND_ARG_END, 1'b0);
          mode = MODE_GAP;
        end else emit_word(c, 16'd1, KIND_CHARS, 1'b0);
      end
      MODE_PATH_PLAIN: begin
        if (e) close_line(KIND_ARG_END);
        else if (is_blank(c)) begin
          emit_word(CH_NUL, '0, KIND_ARG_END, 1'b0);
          mode = MODE_GAP;
        end else emit_word(c, 16'd1, KIND_CHARS, 1'b0);
      end
      MODE_GAP: begin
        if (e) close_line(KIND_LINE_END);
        else if (!is_blank(c)) begin
          clear_arg();
          mode = MODE_ARG;
          arg_char(c, 1'b0);
        end
      end
      MODE_ARG: arg_char(c, e);
      default: begin
        mode = MODE_START;
        clear_arg();
      end
    endcase
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 100) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Predict on accepted input words, compare on accepted result words
  always @(posedge clk) begin
    arg_word_t want;
    arg_word_t got;
    if (!rst_n) begin
      mode = MODE_START;
      clear_arg();
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) split_byte(in_char, in_is_end);
      if (out_valid && !out_stall) begin
        got = '{out_char, out_repeat_res, out_kind, out_line_done, out_run_last};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%02h rep=%0d kind=%0d done=%0b last=%0b",
                                    got.ch, got.rep, got.kind, got.done, got.last));
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (got !== want)
            report_mismatch($sformatf(
              "got char=%02h rep=%0d kind=%0d done=%0b last=%0b, want %02h %0d %0d %0b %0b",
              got.ch, got.rep, got.kind, got.done, got.last,
              want.ch, want.rep, want.kind, want.done, want.last));
        end
      end
    end
    expected_cnt  <= expected_words.size();
    fail_count    <= errors;
    words_checked <= checked;
  end

endmodule

/* tb/tb_top.sv */
// Top of the argv splitter testbench: clock, reset, command line stimulus and verdict.
// Depends on cla_pkg, command_line_arg_splitter and arg_split_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cla_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int WORDS_PER_PHASE = 560;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [CHAR_W-1:0] in_char   = '0;
  logic              in_is_end = 1'b0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic [REP_W-1:0]  out_repeat_res;
  logic [KIND_W-1:0] out_kind;
  logic              out_line_done;
  logic              out_run_last;

  int in_idle_pct  = 0;
  int stall_pct    = 0;
  int words_sent   = 0;
  int quiet_cycles = 0;
  int fail_count;
  int expected_cnt;
  int words_checked;

  always #6 clk = ~clk;

  command_line_arg_splitter #(.RUN_COUNT_BITS(RUN_COUNT_BITS_DEF)) uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_char, .in_is_end,
    .out_valid, .out_stall, .out_char, .out_repeat_res, .out_kind,
    .out_line_done, .out_run_last
  );

  arg_split_checker #(.RUN_COUNT_BITS(RUN_COUNT_BITS_DEF)) split_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_char, .in_is_end,
    .out_valid, .out_stall, .out_char, .out_repeat_res, .out_kind,
    .out_line_done, .out_run_last, .fail_count, .expected_cnt, .words_checked
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= $urandom_range(0, 99) < stall_pct;
  end

  // Count cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Send one word, idling first at random; valid stays high after acceptance
  task automatic put_word(input logic [CHAR_W-1:0] c, input logic e);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_char   <= c;
    in_is_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_word(s[i], 1'b0);
  endtask

  // End marker with a random, ignored byte
  task automatic put_end();
    put_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_cnt != 0) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return 8'h0A;
      2: return 8'h0B;
      3: return 8'h0C;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // Any byte that is neither blank, quote, backslash nor end of line
  function automatic logic [CHAR_W-1:0] pick_text();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 3) != 0) return CHAR_W'(8'h61 + $urandom_range(0, 25));
    do c = CHAR_W'($urandom_range(1, 255));
    while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  // One argument after the program path, built from random pieces
  task automatic put_arg();
    repeat ($urandom_range(1, 3)) put_word(pick_blank(), 1'b0);
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 5))
        0, 1: put_word(pick_text(), 1'b0);
        2: begin
          repeat ($urandom_range(1, 6)) put_word(CH_BSLASH, 1'b0);
          case ($urandom_range(0, 2))
            0: put_word(CH_QUOTE, 1'b0);
            1: put_word(pick_text(), 1'b0);
            default: ;
          endcase
        end
        3: repeat ($urandom_range(1, 4)) put_word(CH_QUOTE, 1'b0);
        4: put_word(pick_blank(), 1'b0);
        default: begin
          put_word(CH_QUOTE, 1'b0);
          put_word(pick_text(), 1'b0);
        end
      endcase
    end
  endtask

  // One command line, well formed most of the time, raw noise otherwise
  task automatic put_line();
    int form;
    form = $urandom_range(0, 11);
    if (form >= 10) begin
      repeat ($urandom_range(1, 6))
        put_word(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    case (form)
      0: ;
      1: put_word(pick_blank(), 1'b0);
      2, 3, 4, 5: begin
        put_word(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: put_word(pick_blank(), 1'b0);
            1: put_word(CH_BSLASH, 1'b0);
            default: put_word(pick_text(), 1'b0);
          endcase
        end
        if ($urandom_range(0, 7) != 0) put_word(CH_QUOTE, 1'b0);
      end
      default: begin
        put_word(pick_text(), 1'b0);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0: put_word(CH_QUOTE, 1'b0);
            1: put_word(CH_BSLASH, 1'b0);
            default: put_word(pick_text(), 1'b0);
          endcase
        end
      end
    endcase
    if (form != 0) repeat ($urandom_range(0, 4)) put_arg();
    if ($urandom_range(0, 3) == 0) put_word(pick_blank(), 1'b0);
    if ($urandom_range(0, 1) == 0) put_end();
    else put_word(CH_NUL, 1'b0);
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 8;
    stall_pct   = 63;

    // Empty line
    put_end();
    // Quoted path, odd and even backslashes before quotes, unclosed quote ended by NUL
    put_text("\"p\" \\\\\\\"\\\\\" ");
    put_word(CH_NUL, 1'b0);
    // Blank at start, top byte, triple quote, quote pair reset, end in a gap
    put_word(CH_TAB, 1'b0);
    put_word(8'hFF, 1'b0);
    put_text(" \"\"\" \"\"z ");
    put_end();

    // Random lines under three idle mixes, each phase starting from a drained block
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 63 : 0;
      stall_pct   = (ph == 0) ? 63 : (ph == 1) ? 8 : 0;
      wait_drained();
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) put_line();
    end

    // Long backslash runs: odd count before a quote, then an even count flushed at line end
    put_text("a ");
    repeat (37) put_word(CH_BSLASH, 1'b0);
    put_word(CH_QUOTE, 1'b0);
    put_end();
    put_text("a ");
    repeat (40) put_word(CH_BSLASH, 1'b0);
    put_end();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered: %0d input words (directed, random lines under three idle mixes,",
             words_sent);
    $display("  two long backslash runs); %0d result words compared", words_checked);
    if (fail_count == 0 && expected_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/cla_pkg.sv
rtl/cla_front.sv
rtl/cla_queue.sv
rtl/cla_back.sv
rtl/command_line_arg_splitter.sv
tb/arg_split_checker.sv
tb/tb_top.sv
